[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the checker files.
// Both macros expect signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFLS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RFLS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/rfls_pkg.sv]
package rfls_pkg;

  // Slot numbers at or above this limit never match.
  localparam int MaxSlots    = 256;
  localparam int OffsetBits  = 16;
  localparam int EntryBytes  = (OffsetBits + 7) / 8;
  localparam int HeaderBytes = 8;
  localparam int ValueBytes  = 8;
  localparam int MaskBits    = 7;
  localparam int MoreBitIdx  = 7;

  localparam int ByteW  = 8;
  localparam int SlotW  = 8;
  localparam int CntW   = 9;
  localparam int RankW  = 8;
  localparam int PosW   = 17;
  localparam int TblW   = 10;
  localparam int CapW   = 4;
  localparam int BaseW  = 32;
  localparam int ValW   = 64;
  localparam int VposW  = 33;

  localparam int InDataW  = 40;
  localparam int OutDataW = 168;
  localparam int OutUserW = 2;

  localparam logic [ByteW-1:0] DataMask = 8'h7F;
  localparam logic [PosW-1:0]  PosMax   = {PosW{1'b1}};
  localparam logic [TblW-1:0]  TblMax   = {TblW{1'b1}};

  typedef enum logic [2:0] {
    PhHeader,
    PhMask,
    PhTable,
    PhWait,
    PhCapture,
    PhDone
  } phase_t;

  typedef enum logic [1:0] {
    StFound  = 2'd0,
    StAbsent = 2'd1,
    StTrunc  = 2'd2,
    StBehind = 2'd3
  } status_t;

  function automatic logic [2:0] popcount7(input logic [MaskBits-1:0] bits);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < MaskBits; i++) begin
      n = n + {2'b00, bits[i]};
    end
    return n;
  endfunction

endpackage

[hw/rtl/record_field_locate_sum.sv]
// The result is registered: out_tvalid rises in the cycle after the item carrying tlast is accepted.
// Throughput: one byte item per cycle; the input stalls only while a finished
//   result waits in the output register and out_tready is low.
// Reset: rst_n is synchronous and active low; it clears the record walk, the
//   running sum, target_slot and the output valid flag.
module record_field_locate_sum (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration write channel: target_slot.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rfls_pkg::SlotW-1:0]     cfg_data,
  // Input stream.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rfls_pkg::InDataW-1:0]   in_tdata,   // data_byte[7:0], record_base[39:8]
  input  logic                           in_tlast,   // last_byte
  // Result stream.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [rfls_pkg::OutDataW-1:0]  out_tdata,  // value_position[32:0],
                                                     // field_value[96:33],
                                                     // running_sum[160:97], zero above
  output logic [rfls_pkg::OutUserW-1:0]  out_tuser   // status[1:0]
);

  // The record is walked as a small state machine that advances once per
  // accepted byte.  Every per-byte update is a handful of narrow compares,
  // a 7-bit population count and counter increments, so the whole step fits
  // between the record state registers and the result register.

  logic                               in_fire;
  logic [rfls_pkg::ByteW-1:0]         data_byte;
  logic [rfls_pkg::BaseW-1:0]         record_base;

  // Configuration.
  logic [rfls_pkg::SlotW-1:0]         target_r;

  // Record walk state.
  rfls_pkg::phase_t                   phase_r, phase_nxt;
  rfls_pkg::status_t                  status_r, status_nxt;
  logic [rfls_pkg::PosW-1:0]          pos_r, pos_nxt;
  logic [rfls_pkg::CntW-1:0]          cnt_r, cnt_nxt;
  logic [rfls_pkg::RankW-1:0]         rank_r, rank_nxt;
  logic                               found_r, found_nxt;
  logic [rfls_pkg::TblW-1:0]          tbl_r, tbl_nxt;
  logic [rfls_pkg::OffsetBits-1:0]    rel_r, rel_nxt;
  logic [rfls_pkg::ValW-1:0]          value_r, value_nxt;
  logic [rfls_pkg::CapW-1:0]          cap_r, cap_nxt;
  logic [rfls_pkg::BaseW-1:0]         base_r, base_nxt;
  logic [rfls_pkg::ValW-1:0]          sum_r, sum_nxt;

  // Output register.
  logic                               out_valid_r, out_valid_nxt;
  rfls_pkg::status_t                  out_status_r, out_status_nxt;
  logic [rfls_pkg::VposW-1:0]         out_vpos_r, out_vpos_nxt;
  logic [rfls_pkg::ValW-1:0]          out_fval_r, out_fval_nxt;
  logic [rfls_pkg::ValW-1:0]          out_sum_r, out_sum_nxt;

  // Mask walk helpers.
  logic [rfls_pkg::MaskBits-1:0]      mask_bits;
  logic                               slot_ge;
  logic [rfls_pkg::CntW-1:0]          slot_diff;
  logic                               slot_in_byte;
  logic                               slot_hit;
  logic [2:0]                         hit_idx;
  logic [2:0]                         below_n;
  logic [rfls_pkg::ByteW-1:0]         below_ones;
  logic [2:0]                         below_cnt;

  // Offset table helpers.
  logic [rfls_pkg::TblW-1:0]          entry_first;
  logic [rfls_pkg::TblW-1:0]          entry_k;
  logic                               entry_ge;
  logic                               entry_in;
  logic [rfls_pkg::OffsetBits-1:0]    rel_merged;

  // Value capture helpers.
  logic                               cap_do;
  logic [rfls_pkg::CapW-1:0]          cap_inc;
  logic [rfls_pkg::ValW-1:0]          value_merged;

  logic                               pos_zero;
  rfls_pkg::status_t                  result_status;

  assign data_byte   = in_tdata[rfls_pkg::ByteW-1:0];
  assign record_base = in_tdata[rfls_pkg::ByteW +: rfls_pkg::BaseW];

  // A result waiting in the output register holds off only when it cannot
  // leave in this same cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign pos_zero = (pos_r == '0);

  // Slot numbers covered by this mask byte are cnt_r .. cnt_r+6.  The target
  // lies in this byte when it is at or above cnt_r and less than seven past
  // it; bits below the target position are present entries ahead of it.
  assign mask_bits    = data_byte[rfls_pkg::MaskBits-1:0];
  assign slot_ge      = {1'b0, target_r} >= cnt_r;
  assign slot_diff    = {1'b0, target_r} - cnt_r;
  assign slot_in_byte = slot_ge && (slot_diff < rfls_pkg::CntW'(rfls_pkg::MaskBits));
  assign slot_hit     = slot_in_byte
                        && ({1'b0, target_r} < rfls_pkg::CntW'(rfls_pkg::MaxSlots));
  assign hit_idx      = slot_diff[2:0];
  assign below_n      = !slot_ge     ? 3'd0 :
                        slot_in_byte ? slot_diff[2:0] : 3'(rfls_pkg::MaskBits);
  assign below_ones   = (rfls_pkg::ByteW'(1) << below_n) - rfls_pkg::ByteW'(1);
  assign below_cnt    = rfls_pkg::popcount7(mask_bits
                                            & below_ones[rfls_pkg::MaskBits-1:0]);

  // The wanted entry starts rank * entry-size bytes into the table.
  assign entry_first = rfls_pkg::TblW'(rank_r) * rfls_pkg::TblW'(rfls_pkg::EntryBytes);
  assign entry_ge    = tbl_r >= entry_first;
  assign entry_k     = tbl_r - entry_first;
  assign entry_in    = entry_ge && (entry_k < rfls_pkg::TblW'(rfls_pkg::EntryBytes));
  assign rel_merged  = rel_r | rfls_pkg::OffsetBits'(
                         {{(rfls_pkg::EntryBytes * 8 - rfls_pkg::ByteW){1'b0}}, data_byte}
                         << {entry_k, 3'b000});

  // Value bytes arrive little-endian, one per cycle while the input is not stalled.
  assign cap_inc      = cap_r + rfls_pkg::CapW'(1);
  assign value_merged = value_r | ({{(rfls_pkg::ValW - rfls_pkg::ByteW){1'b0}}, data_byte}
                                   << {cap_r[2:0], 3'b000});

  always_comb begin
    phase_nxt      = phase_r;
    status_nxt     = status_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    rank_nxt       = rank_r;
    found_nxt      = found_r;
    tbl_nxt        = tbl_r;
    rel_nxt        = rel_r;
    value_nxt      = value_r;
    cap_nxt        = cap_r;
    base_nxt       = base_r;
    sum_nxt        = sum_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_vpos_nxt   = out_vpos_r;
    out_fval_nxt   = out_fval_r;
    out_sum_nxt    = out_sum_r;
    cap_do         = 1'b0;
    result_status  = rfls_pkg::StTrunc;

    if (in_fire) begin
      if (pos_zero) begin
        base_nxt = record_base;
      end

      unique case (phase_r)
        rfls_pkg::PhHeader: begin
          if (pos_r >= rfls_pkg::PosW'(rfls_pkg::HeaderBytes - 1)) begin
            phase_nxt = rfls_pkg::PhMask;
          end
        end
        rfls_pkg::PhMask: begin
          if (slot_hit && !mask_bits[hit_idx]) begin
            // The target's presence bit is clear.
            status_nxt = rfls_pkg::StAbsent;
            phase_nxt  = rfls_pkg::PhDone;
          end else begin
            rank_nxt  = rank_r + rfls_pkg::RankW'(below_cnt);
            found_nxt = found_r || slot_hit;
            if (slot_ge) begin
              cnt_nxt = cnt_r + rfls_pkg::CntW'(rfls_pkg::MaskBits);
            end
            if (!data_byte[rfls_pkg::MoreBitIdx]) begin
              if (found_r || slot_hit) begin
                phase_nxt = rfls_pkg::PhTable;
              end else begin
                // The mask ended before reaching the target slot.
                status_nxt = rfls_pkg::StAbsent;
                phase_nxt  = rfls_pkg::PhDone;
              end
            end
          end
        end
        rfls_pkg::PhTable: begin
          if (tbl_r != rfls_pkg::TblMax) begin
            tbl_nxt = tbl_r + rfls_pkg::TblW'(1);
          end
          if (entry_in) begin
            rel_nxt = rel_merged;
            if (entry_k == rfls_pkg::TblW'(rfls_pkg::EntryBytes - 1)) begin
              // An offset at or before the current byte can no longer be reached.
              if ({1'b0, rel_merged} <= pos_r) begin
                status_nxt = rfls_pkg::StBehind;
                phase_nxt  = rfls_pkg::PhDone;
              end else begin
                phase_nxt = rfls_pkg::PhWait;
              end
            end
          end
        end
        rfls_pkg::PhWait: begin
          if (pos_r >= {1'b0, rel_r}) begin
            phase_nxt = rfls_pkg::PhCapture;
            cap_do    = 1'b1;
          end
        end
        rfls_pkg::PhCapture: begin
          cap_do = 1'b1;
        end
        rfls_pkg::PhDone: begin
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase

      if (cap_do) begin
        value_nxt = value_merged;
        cap_nxt   = cap_inc;
        if (cap_inc >= rfls_pkg::CapW'(rfls_pkg::ValueBytes)) begin
          status_nxt = rfls_pkg::StFound;
          phase_nxt  = rfls_pkg::PhDone;
        end
      end

      if (pos_r != rfls_pkg::PosMax) begin
        pos_nxt = pos_r + rfls_pkg::PosW'(1);
      end

      if (in_tlast) begin
        // A record that ends before its status is settled is truncated.
        if (phase_nxt == rfls_pkg::PhDone) begin
          result_status = status_nxt;
        end
        out_valid_nxt  = 1'b1;
        out_status_nxt = result_status;
        if (result_status == rfls_pkg::StFound) begin
          sum_nxt      = sum_r + value_nxt;
          out_vpos_nxt = rfls_pkg::VposW'(base_nxt) + rfls_pkg::VposW'(rel_nxt);
          out_fval_nxt = value_nxt;
        end else begin
          out_vpos_nxt = '0;
          out_fval_nxt = '0;
        end
        out_sum_nxt = sum_nxt;

        // Start the next record from a clean walk; the sum carries over.
        phase_nxt  = rfls_pkg::PhHeader;
        status_nxt = rfls_pkg::StFound;
        pos_nxt    = '0;
        cnt_nxt    = '0;
        rank_nxt   = '0;
        found_nxt  = 1'b0;
        tbl_nxt    = '0;
        rel_nxt    = '0;
        value_nxt  = '0;
        cap_nxt    = '0;
        base_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= '0;
      phase_r     <= rfls_pkg::PhHeader;
      status_r    <= rfls_pkg::StFound;
      pos_r       <= '0;
      cnt_r       <= '0;
      rank_r      <= '0;
      found_r     <= 1'b0;
      tbl_r       <= '0;
      rel_r       <= '0;
      value_r     <= '0;
      cap_r       <= '0;
      base_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        target_r <= cfg_data;
      end
      phase_r     <= phase_nxt;
      status_r    <= status_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      rank_r      <= rank_nxt;
      found_r     <= found_nxt;
      tbl_r       <= tbl_nxt;
      rel_r       <= rel_nxt;
      value_r     <= value_nxt;
      cap_r       <= cap_nxt;
      base_r      <= base_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset; it is only looked at while valid.
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_vpos_r   <= out_vpos_nxt;
    out_fval_r   <= out_fval_nxt;
    out_sum_r    <= out_sum_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(rfls_pkg::OutDataW - rfls_pkg::VposW - 2 * rfls_pkg::ValW){1'b0}},
                       out_sum_r, out_fval_r, out_vpos_r};

endmodule

[hw/rtl/rfls_checker.sv]
`include "assert_macros.svh"

module rfls_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           in_tlast,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [rfls_pkg::OutDataW-1:0]  out_tdata,
  input logic [rfls_pkg::OutUserW-1:0]  out_tuser
);

  // A stalled result keeps its contents.
  `RFLS_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // Only a found result carries a position and a value.
  `RFLS_ASSERT_IMP(a_nonfound_zero, out_tvalid && (out_tuser != rfls_pkg::StFound), out_tdata[96:0] == '0, "non-found result carries data")

  // A fresh result follows an accepted last byte.
  `RFLS_ASSERT_IMP(a_result_cause, $rose(out_tvalid), $past(in_tvalid && in_tready && in_tlast), "result without a last byte")

  // With the output register empty the input is never held off.
  `RFLS_ASSERT_IMP(a_in_open, !out_tvalid, in_tready, "input stalled with empty output")

endmodule

bind record_field_locate_sum rfls_checker u_rfls_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
